@@ hw/rtl/fpa_pkg.sv @@
// Shared types, widths and command codes of the fixed-point ALU.
// Used by every module of the block; depends on nothing.
package fpa_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 8;
    localparam int NUM_WIDTH  = DATA_WIDTH + FRAC_BITS;
    localparam int PROD_WIDTH = 2 * DATA_WIDTH;

    localparam logic [3:0] CMD_ADD      = 4'd0;
    localparam logic [3:0] CMD_SUB      = 4'd1;
    localparam logic [3:0] CMD_MUL      = 4'd2;
    localparam logic [3:0] CMD_DIV      = 4'd3;
    localparam logic [3:0] CMD_GT       = 4'd4;
    localparam logic [3:0] CMD_LT       = 4'd5;
    localparam logic [3:0] CMD_GE       = 4'd6;
    localparam logic [3:0] CMD_LE       = 4'd7;
    localparam logic [3:0] CMD_EQ       = 4'd8;
    localparam logic [3:0] CMD_NE       = 4'd9;
    localparam logic [3:0] CMD_MIN      = 4'd10;
    localparam logic [3:0] CMD_MAX      = 4'd11;
    localparam logic [3:0] CMD_INC      = 4'd12;
    localparam logic [3:0] CMD_FROM_INT = 4'd13;
    localparam logic [3:0] CMD_TO_INT   = 4'd14;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MIN_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [3:0]                   command;
        logic signed [DATA_WIDTH-1:0] operand_a;
        logic signed [DATA_WIDTH-1:0] operand_b;
    } t_req;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] result_value;
        logic                         compare_true;
        logic [1:0]                   status;
    } t_rsp;

    // Everything one request carries down the pipeline.
    typedef struct packed {
        logic [3:0]            command;
        logic                  res_neg;
        logic                  a_neg;
        logic                  div0;
        logic [DATA_WIDTH-1:0] value;
        logic                  cmp;
        logic [1:0]            status;
        logic [PROD_WIDTH-1:0] prod;
        logic [NUM_WIDTH-1:0]  num;
        logic [NUM_WIDTH-1:0]  quo;
        logic [DATA_WIDTH-1:0] rem;
        logic [DATA_WIDTH-1:0] den;
    } t_pipe;

endpackage

@@ hw/rtl/fixed_point_alu.sv @@
// Top level of the Q24.8 fixed-point ALU: front stage, divider step chain
// and back stage. Depends on fpa_pkg, fpa_front, fpa_div_step and fpa_back.
//
// Every request, whatever its command, passes through a fixed pipeline of
// NUM_WIDTH + 2 stages, NUM_WIDTH being 40 in the default Q24.8 configuration,
// and a new request may enter in every cycle while the pipeline is not halted.
// The depth is set by the restoring divider, which retires one quotient bit per
// stage over the 40-bit scaled numerator. The whole pipeline advances together
// and halts only while a response waits at the output under stall.
module fixed_point_alu import fpa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    logic  en;
    logic  stg_valid [NUM_WIDTH+1];
    t_pipe stg_pipe  [NUM_WIDTH+1];

    // Advance everywhere unless the held response is still stalled.
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    fpa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_req   (i_req),
        .o_valid (stg_valid[0]),
        .o_pipe  (stg_pipe[0])
    );

    // One divider step per quotient bit.
    for (genvar k = 0; k < NUM_WIDTH; k++) begin : g_div
        fpa_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (stg_valid[k]),
            .i_pipe  (stg_pipe[k]),
            .o_valid (stg_valid[k+1]),
            .o_pipe  (stg_pipe[k+1])
        );
    end

    fpa_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (stg_valid[NUM_WIDTH]),
        .i_pipe  (stg_pipe[NUM_WIDTH]),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

endmodule

@@ hw/rtl/fpa_front.sv @@
// First stage: decodes the command, computes the add, subtract, compare, min,
// max, increment and conversion results, the operand magnitudes and the magnitude product. Depends on fpa_pkg.
module fpa_front import fpa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_req  i_req,
    output logic  o_valid,
    output t_pipe o_pipe
);

    logic [DATA_WIDTH-1:0] a, b, ma, mb, sum, dif, a_key, b_key;
    logic                  a_neg, b_neg, lt_ab, lt_ba, eq_ab;
    logic [FRAC_BITS:0]    top;
    t_pipe                 n_pipe;
    logic                  r_valid;
    t_pipe                 r_pipe;

    always_comb begin
        a     = i_req.operand_a;
        b     = i_req.operand_b;
        a_neg = a[DATA_WIDTH-1];
        b_neg = b[DATA_WIDTH-1];
        ma    = a_neg ? (~a + 1'b1) : a;
        mb    = b_neg ? (~b + 1'b1) : b;
        sum   = a + b;
        dif   = a - b;
        // Flipping the sign bit orders two's complement values as unsigned.
        a_key = {~a[DATA_WIDTH-1], a[DATA_WIDTH-2:0]};
        b_key = {~b[DATA_WIDTH-1], b[DATA_WIDTH-2:0]};
        lt_ab = a_key < b_key;
        lt_ba = b_key < a_key;
        eq_ab = a == b;
        top   = a[DATA_WIDTH-1 -: FRAC_BITS+1];

        n_pipe         = '0;
        n_pipe.command = i_req.command;
        n_pipe.a_neg   = a_neg;
        n_pipe.res_neg = a_neg ^ b_neg;
        n_pipe.div0    = (mb == '0);
        n_pipe.status  = ST_OK;
        n_pipe.prod    = PROD_WIDTH'(ma) * PROD_WIDTH'(mb);
        n_pipe.num     = {ma, {FRAC_BITS{1'b0}}};
        n_pipe.den     = mb;

        case (i_req.command)
            CMD_ADD: begin
                n_pipe.value = sum;
                if (a_neg == b_neg && sum[DATA_WIDTH-1] != a_neg) begin
                    n_pipe.status = ST_OVF;
                    n_pipe.value  = a_neg ? MIN_NEG : MAX_POS;
                end
            end
            CMD_SUB: begin
                n_pipe.value = dif;
                if (a_neg != b_neg && dif[DATA_WIDTH-1] != a_neg) begin
                    n_pipe.status = ST_OVF;
                    n_pipe.value  = a_neg ? MIN_NEG : MAX_POS;
                end
            end
            CMD_GT:  n_pipe.cmp = lt_ba;
            CMD_LT:  n_pipe.cmp = lt_ab;
            CMD_GE:  n_pipe.cmp = !lt_ab;
            CMD_LE:  n_pipe.cmp = !lt_ba;
            CMD_EQ:  n_pipe.cmp = eq_ab;
            CMD_NE:  n_pipe.cmp = !eq_ab;
            CMD_MIN: n_pipe.value = lt_ab ? a : b;
            CMD_MAX: n_pipe.value = lt_ba ? a : b;
            CMD_INC: begin
                if (a == MAX_POS) begin
                    n_pipe.status = ST_OVF;
                    n_pipe.value  = a;
                end else begin
                    n_pipe.value = a + 1'b1;
                end
            end
            CMD_FROM_INT: begin
                if ((&top) || !(|top)) begin
                    n_pipe.value = {a[DATA_WIDTH-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
                end else begin
                    n_pipe.status = ST_OVF;
                    n_pipe.value  = a_neg ? MIN_NEG : MAX_POS;
                end
            end
            CMD_TO_INT: n_pipe.value = {{FRAC_BITS{a_neg}}, a[DATA_WIDTH-1:FRAC_BITS]};
            default: n_pipe.value = '0;
        endcase
    end

    // Stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe <= n_pipe;
        end
    end

    assign o_valid = r_valid;
    assign o_pipe  = r_pipe;

endmodule

@@ hw/rtl/fpa_div_step.sv @@
// One registered step of the restoring divider: brings down one numerator
// bit and subtracts the divisor where it fits. Depends on fpa_pkg.
module fpa_div_step import fpa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_pipe i_pipe,
    output logic  o_valid,
    output t_pipe o_pipe
);

    logic [DATA_WIDTH:0] trial;
    logic                fits;
    t_pipe               n_pipe;
    logic                r_valid;
    t_pipe               r_pipe;

    // The remainder stays below the divisor, so the trial value is one bit wider.
    always_comb begin
        trial  = {i_pipe.rem, i_pipe.num[NUM_WIDTH-1]};
        fits   = trial >= {1'b0, i_pipe.den};
        n_pipe = i_pipe;
        n_pipe.num = {i_pipe.num[NUM_WIDTH-2:0], 1'b0};
        n_pipe.quo = {i_pipe.quo[NUM_WIDTH-2:0], fits};
        n_pipe.rem = fits ? DATA_WIDTH'(trial - {1'b0, i_pipe.den})
                          : trial[DATA_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe <= n_pipe;
        end
    end

    assign o_valid = r_valid;
    assign o_pipe  = r_pipe;

endmodule

@@ hw/rtl/fpa_back.sv @@
// Last stage: rounds the product and the quotient, saturates, and holds the
// response register. Depends on fpa_pkg.
module fpa_back import fpa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_pipe i_pipe,
    output logic  o_valid,
    output t_rsp  o_rsp
);

    localparam int MUL_MAG_W = PROD_WIDTH + 1 - FRAC_BITS;
    localparam int DIV_MAG_W = NUM_WIDTH + 1;

    logic [PROD_WIDTH:0]   prod_rnd;
    logic [MUL_MAG_W-1:0]  mul_mag;
    logic [DIV_MAG_W-1:0]  div_mag;
    logic [DATA_WIDTH:0]   rem2;
    logic [DATA_WIDTH-1:0] mul_val, div_val;
    logic                  mul_ovf, div_ovf;
    t_rsp                  n_rsp;
    logic                  r_valid;
    t_rsp                  r_rsp;

    always_comb begin
        // Round the product to nearest, halves away from zero, on the magnitude.
        prod_rnd = {1'b0, i_pipe.prod} + (PROD_WIDTH+1)'(1) * (1 << (FRAC_BITS-1));
        mul_mag  = prod_rnd[PROD_WIDTH:FRAC_BITS];
        if (i_pipe.res_neg) begin
            mul_ovf = mul_mag > MUL_MAG_W'(MIN_NEG);
            mul_val = mul_ovf ? MIN_NEG : DATA_WIDTH'(~mul_mag + 1'b1);
        end else begin
            mul_ovf = mul_mag > MUL_MAG_W'(MAX_POS);
            mul_val = mul_ovf ? MAX_POS : mul_mag[DATA_WIDTH-1:0];
        end

        // The quotient rounds up when twice the remainder reaches the divisor.
        rem2    = {i_pipe.rem, 1'b0};
        div_mag = {1'b0, i_pipe.quo} + DIV_MAG_W'(rem2 >= {1'b0, i_pipe.den});
        if (i_pipe.res_neg) begin
            div_ovf = div_mag > DIV_MAG_W'(MIN_NEG);
            div_val = div_ovf ? MIN_NEG : DATA_WIDTH'(~div_mag + 1'b1);
        end else begin
            div_ovf = div_mag > DIV_MAG_W'(MAX_POS);
            div_val = div_ovf ? MAX_POS : div_mag[DATA_WIDTH-1:0];
        end

        n_rsp.result_value = i_pipe.value;
        n_rsp.compare_true = i_pipe.cmp;
        n_rsp.status       = i_pipe.status;
        case (i_pipe.command)
            CMD_MUL: begin
                n_rsp.result_value = mul_val;
                n_rsp.status       = mul_ovf ? ST_OVF : ST_OK;
            end
            CMD_DIV: begin
                if (i_pipe.div0) begin
                    n_rsp.result_value = i_pipe.a_neg ? MIN_NEG : MAX_POS;
                    n_rsp.status       = ST_DIV0;
                end else begin
                    n_rsp.result_value = div_val;
                    n_rsp.status       = div_ovf ? ST_OVF : ST_OK;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

@@ test/fpa_checker.sv @@
// Checker of the fixed-point ALU: predicts each response from the accepted requests
// and compares it field by field. Depends on fpa_pkg.
module fpa_checker import fpa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_req_stall,
    input  t_req i_req,
    input  logic i_rsp_valid,
    input  logic i_rsp_stall,
    input  t_rsp i_rsp,
    output int   o_errors,
    output int   o_pending,
    output int   o_responses
);

    t_rsp expected_rsps[$];

    // Saturating pack of a sign and a wide magnitude.
    function automatic logic [31:0] sat_pack(input logic neg, input logic [127:0] mag,
                                             inout logic [1:0] st);
        if (neg) begin
            if (mag > 128'h8000_0000) begin
                st = ST_OVF;
                return MIN_NEG;
            end
            return 32'(-mag);
        end
        if (mag > 128'h7FFF_FFFF) begin
            st = ST_OVF;
            return MAX_POS;
        end
        return mag[31:0];
    endfunction

    // Expected response of one request.
    function automatic t_rsp alu_predict(input t_req rq);
        t_rsp r;
        logic signed [31:0] a, b;
        logic signed [32:0] wide;
        logic [127:0] ma, mb, prod, num, q, rem;
        logic [1:0] st;
        a = rq.operand_a;
        b = rq.operand_b;
        ma = a[31] ? 128'(-{1'b1, a}) & 128'hFFFF_FFFF : 128'(unsigned'(a));
        mb = b[31] ? 128'(-{1'b1, b}) & 128'hFFFF_FFFF : 128'(unsigned'(b));
        if (a == MIN_NEG) ma = 128'h8000_0000;
        if (b == MIN_NEG) mb = 128'h8000_0000;
        st = ST_OK;
        r = '0;
        case (rq.command)
            CMD_ADD, CMD_SUB: begin
                wide = (rq.command == CMD_ADD) ? a + b : a - b;
                if (wide > 33'sh7FFF_FFFF) begin
                    st = ST_OVF;
                    r.result_value = MAX_POS;
                end else if (wide < -33'sh8000_0000) begin
                    st = ST_OVF;
                    r.result_value = MIN_NEG;
                end else begin
                    r.result_value = wide[31:0];
                end
            end
            CMD_MUL: begin
                prod = (ma * mb + 128'd128) >> FRAC_BITS;
                r.result_value = sat_pack(a[31] ^ b[31], prod, st);
            end
            CMD_DIV: begin
                if (mb == 0) begin
                    st = ST_DIV0;
                    r.result_value = a[31] ? MIN_NEG : MAX_POS;
                end else begin
                    num = ma << FRAC_BITS;
                    q = num / mb;
                    rem = num % mb;
                    if (rem >= mb - rem) q = q + 1;
                    r.result_value = sat_pack(a[31] ^ b[31], q, st);
                end
            end
            CMD_GT:  r.compare_true = a > b;
            CMD_LT:  r.compare_true = a < b;
            CMD_GE:  r.compare_true = a >= b;
            CMD_LE:  r.compare_true = a <= b;
            CMD_EQ:  r.compare_true = a == b;
            CMD_NE:  r.compare_true = a != b;
            CMD_MIN: r.result_value = (a < b) ? a : b;
            CMD_MAX: r.result_value = (b < a) ? a : b;
            CMD_INC: begin
                if (a == MAX_POS) begin
                    st = ST_OVF;
                    r.result_value = a;
                end else begin
                    r.result_value = a + 1;
                end
            end
            CMD_FROM_INT: begin
                if (a > 32'sh007F_FFFF) begin
                    st = ST_OVF;
                    r.result_value = MAX_POS;
                end else if (a < -32'sh0080_0000) begin
                    st = ST_OVF;
                    r.result_value = MIN_NEG;
                end else begin
                    r.result_value = a <<< FRAC_BITS;
                end
            end
            CMD_TO_INT: r.result_value = a >>> FRAC_BITS;
            default: ;
        endcase
        r.status = st;
        return r;
    endfunction

    assign o_pending = expected_rsps.size();

    // Record requests and compare responses at the rising edge.
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            o_errors    <= 0;
            o_responses <= 0;
        end else begin
            if (i_valid && !i_req_stall) expected_rsps.push_back(alu_predict(i_req));
            if (i_rsp_valid && !i_rsp_stall) begin
                o_responses <= o_responses + 1;
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected response %h", $time, i_rsp);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_rsps.pop_front();
                    if (want !== i_rsp) begin
                        $display("%0t: mismatch expected value %h cmp %b st %0d, got %h %b %0d",
                                 $time, want.result_value, want.compare_true, want.status,
                                 i_rsp.result_value, i_rsp.compare_true, i_rsp.status);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

@@ test/fixed_point_alu_tb.sv @@
// Testbench top of the fixed-point ALU: drives directed and random requests with
// random gaps and stalls and reports the verdict. Depends on fpa_pkg and fpa_checker.
module fixed_point_alu_tb;
    import fpa_pkg::*;

    localparam int LATENCY = NUM_WIDTH + 2;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall, o_valid;
    t_req i_req = '0;
    t_rsp o_rsp;
    int   errors, pending, responses;
    int   sent = 0;

    fixed_point_alu dut (.*);

    fpa_checker checker_i (
        .i_clk, .i_rst_n, .i_valid, .i_req_stall(o_stall), .i_req,
        .i_rsp_valid(o_valid), .i_rsp_stall(i_stall), .i_rsp(o_rsp),
        .o_errors(errors), .o_pending(pending), .o_responses(responses)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Random operand biased toward edge values.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return MAX_POS;
            1: return MIN_NEG;
            2: return 32'(int'($urandom_range(0, 8)) - 4);
            3: return 32'(int'($urandom_range(0, 4096)) - 2048);
            4: return 32'(int'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000);
            default: return $urandom();
        endcase
    endfunction

    // Send one request, with a random gap before it. Valid stays high after the
    // request is taken so that a request without a gap follows directly.
    task automatic send_request(input logic [3:0] cmd, input logic [31:0] a,
                                input logic [31:0] b);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req   <= '{command: cmd, operand_a: a, operand_b: b};
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        sent++;
        @(negedge i_clk);
    endtask

    // Output stall: random, with calm stretches.
    always @(negedge i_clk) begin
        int hold;
        if ($urandom_range(0, 40) == 0) begin
            hold = $urandom_range(1, 60);
            i_stall <= 1'b0;
            repeat (hold) @(negedge i_clk);
        end
        hold = $urandom_range(0, 7);
        if (hold > 4) begin
            i_stall <= 1'b1;
            repeat (hold - 4) @(negedge i_clk);
        end
        i_stall <= 1'b0;
    end

    initial begin
        logic [31:0] edges[6];
        edges = '{MAX_POS, MIN_NEG, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'h0000_0180};
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // Directed: every command on edge operands, overflow and divide by zero.
        for (int c = 0; c < 16; c++) send_request(4'(c), edges[c % 6], edges[(c + 1) % 6]);
        send_request(CMD_DIV, 32'd0, 32'd0);
        send_request(CMD_DIV, MIN_NEG, 32'd0);
        send_request(CMD_DIV, MIN_NEG, 32'd1);
        send_request(CMD_MUL, MIN_NEG, MIN_NEG);
        send_request(CMD_MUL, 32'h0000_0180, 32'hFFFF_FF80);
        send_request(CMD_FROM_INT, 32'h007F_FFFF, 32'd0);
        send_request(CMD_FROM_INT, 32'hFF80_0000, 32'd0);
        send_request(CMD_INC, MAX_POS, 32'd0);
        // Let the pipeline drain completely once.
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        for (int n = 0; n < 1550; n++)
            send_request(4'($urandom_range(0, 15)), pick_operand(), pick_operand());
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        $display("Sent %0d requests across all commands and edge operands; %0d responses.",
                 sent, responses);
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
